// ----- rtl/satlu_pkg.sv -----
package satlu_pkg;

  // Fixed field widths of the lookup channel.
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned WAY_OUT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_SET_BITS    = 2'd1,
    CFG_WAYS_IN_USE = 2'd2,
    CFG_FIFO_MODE   = 2'd3
  } cfg_reg_e;

  localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
  localparam logic [2:0] SET_BITS_RST    = 3'd6;
  localparam logic [2:0] WAYS_RST        = 3'd4;
  localparam logic       FIFO_MODE_RST   = 1'b0;

  // Outcome of comparing one stored way against the lookup.
  typedef struct packed {
    logic match;   // valid way holding the lookup tag
    logic empty;   // way not yet filled
    logic older;   // stamp below the best seen so far, or first way
  } cmp_res_t;

  // Write strobes into the line store.
  typedef struct packed {
    logic tag_we;
    logic stamp_we;
    logic valid_set;
  } store_wr_t;

endpackage

// ----- rtl/satlu_store.sv -----
module satlu_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_addr_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  satlu_pkg::store_wr_t         wr_i,
  input  logic [satlu_pkg::TAG_W-1:0]  wr_tag_i,
  input  logic [satlu_pkg::STAMP_W-1:0] wr_stamp_i,
  output logic                         rd_valid_o,
  output logic [satlu_pkg::TAG_W-1:0]  rd_tag_o,
  output logic [satlu_pkg::STAMP_W-1:0] rd_stamp_o
);
  import satlu_pkg::*;

  logic [TAG_W-1:0]   tag_mem   [DEPTH];
  logic [STAMP_W-1:0] stamp_mem [DEPTH];
  logic [DEPTH-1:0]   valid_q;

  // Valid bits live in flops so that reset empties the whole store at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.valid_set) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_o <= 1'b0;
    end else if (rd_en_i) begin
      rd_valid_o <= valid_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.tag_we) begin
      tag_mem[wr_addr_i] <= wr_tag_i;
    end
    if (wr_i.stamp_we) begin
      stamp_mem[wr_addr_i] <= wr_stamp_i;
    end
    if (rd_en_i) begin
      rd_tag_o   <= tag_mem[rd_addr_i];
      rd_stamp_o <= stamp_mem[rd_addr_i];
    end
  end

endmodule

// ----- rtl/satlu_way_cmp.sv -----
module satlu_way_cmp (
  input  logic                          ent_valid_i,
  input  logic [satlu_pkg::TAG_W-1:0]   ent_tag_i,
  input  logic [satlu_pkg::STAMP_W-1:0] ent_stamp_i,
  input  logic [satlu_pkg::TAG_W-1:0]   look_tag_i,
  input  logic [satlu_pkg::STAMP_W-1:0] best_stamp_i,
  input  logic                          first_i,
  output satlu_pkg::cmp_res_t           res_o
);
  import satlu_pkg::*;

  // Strict compare keeps the lowest way on equal stamps.
  always_comb begin
    res_o.match = ent_valid_i && (ent_tag_i == look_tag_i);
    res_o.empty = !ent_valid_i;
    res_o.older = first_i || (ent_stamp_i < best_stamp_i);
  end

endmodule

// ----- rtl/set_associative_cache_tag_lookup_unit.sv -----
// Set-associative tag lookup with LRU or FIFO replacement. Each input transaction carries one
// byte address; the configured offset and set bit counts split it into set and tag, the set's
// ways are examined one after another through a single tag/stamp compare unit, and one result
// transaction reports hit or miss, the way used, whether an empty way was filled and the tag
// of any evicted line. Each transaction runs through an accept step, then for each of the n ways
// examined (the search stops at the first hit, otherwise n is the number of ways in use) a
// read of the single-ported line store with registered output and a compare, and finally an
// update step that writes the chosen way back (a hit in FIFO mode writes nothing); only then
// is the next transaction accepted. The update is held for as long as the previous result is
// still waiting in the output register, so a stalled result side delays it. The valid bits
// are cleared by reset all at once; tags and stamps are only ever read behind a valid bit.
// Configuration may only be written while no transaction is in flight.
module set_associative_cache_tag_lookup_unit #(
  parameter int unsigned MAX_SETS   = 64,
  parameter int unsigned MAX_WAYS   = 4,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // lookup request
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [satlu_pkg::ADDR_W-1:0]     address_i,
  // lookup result
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic [satlu_pkg::WAY_OUT_W-1:0]  way_o,
  output logic                             filled_empty_o,
  output logic                             evicted_o,
  output logic [satlu_pkg::TAG_W-1:0]      evicted_tag_o,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [satlu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [satlu_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import satlu_pkg::*;

  localparam int unsigned DEPTH  = MAX_SETS * MAX_WAYS;
  localparam int unsigned MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  // The raw set index is at most seven bits wide (set_bits can hold seven).
  localparam int unsigned SRAW_N = 128;
  localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_WIDTH >= ADDR_W) ? '1 :
      ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_UPDATE
  } state_e;

  // Configuration registers.
  logic [4:0] offset_bits_q;
  logic [2:0] set_bits_q;
  logic [2:0] ways_q;
  logic       fifo_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= OFFSET_BITS_RST;
      set_bits_q    <= SET_BITS_RST;
      ways_q        <= WAYS_RST;
      fifo_mode_q   <= FIFO_MODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata_i;
        CFG_SET_BITS:    set_bits_q    <= cfg_wdata_i[2:0];
        CFG_WAYS_IN_USE: ways_q        <= cfg_wdata_i[2:0];
        CFG_FIFO_MODE:   fifo_mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Address split. Sets beyond the store alias back onto it, which the table below folds
  // in; it is worked out entirely at elaboration.
  logic [SET_W-1:0] set_fold [SRAW_N];
  for (genvar g = 0; g < SRAW_N; g++) begin : g_fold
    assign set_fold[g] = SET_W'(g % MAX_SETS);
  end

  logic [ADDR_W-1:0] addr_m;
  logic [6:0]        set_mask;
  logic [6:0]        set_raw;
  logic [5:0]        tag_shamt;
  logic [TAG_W-1:0]  look_tag;
  logic [MEM_AW-1:0] look_base;
  logic [WAY_W-1:0]  look_last;

  always_comb begin
    addr_m    = address_i & ADDR_MASK;
    set_mask  = 7'((8'd1 << set_bits_q) - 8'd1);
    set_raw   = 7'(addr_m >> offset_bits_q) & set_mask;
    tag_shamt = 6'(offset_bits_q) + 6'(set_bits_q);
    // A shift of the full width or more leaves a zero tag.
    look_tag  = TAG_W'(addr_m >> tag_shamt);
    look_base = MEM_AW'(int'(set_fold[set_raw]) * MAX_WAYS);
    // Zero ways counts as one; more than the store holds counts as all of them.
    if (ways_q == 3'd0) begin
      look_last = '0;
    end else if (int'(ways_q) > MAX_WAYS) begin
      look_last = WAY_W'(MAX_WAYS - 1);
    end else begin
      look_last = WAY_W'(ways_q - 3'd1);
    end
  end

  // Sequencer registers.
  state_e            state_q;
  logic [TAG_W-1:0]  tag_q;
  logic [MEM_AW-1:0] base_q;
  logic [WAY_W-1:0]  last_q;
  logic [WAY_W-1:0]  way_q;
  logic              hit_q;
  logic [WAY_W-1:0]  hit_way_q;
  logic              empty_found_q;
  logic [WAY_W-1:0]  empty_way_q;
  logic [WAY_W-1:0]  best_way_q;
  logic [STAMP_W-1:0] best_stamp_q;
  logic [TAG_W-1:0]  best_tag_q;
  logic [STAMP_W-1:0] count_q;

  // Output register.
  logic                 out_valid_q;
  logic                 out_hit_q;
  logic [WAY_OUT_W-1:0] out_way_q;
  logic                 out_filled_q;
  logic                 out_evicted_q;
  logic [TAG_W-1:0]     out_evtag_q;

  logic               in_fire;
  logic               upd_fire;
  logic               rd_en;
  logic [MEM_AW-1:0]  rd_addr;
  logic               rd_valid;
  logic [TAG_W-1:0]   rd_tag;
  logic [STAMP_W-1:0] rd_stamp;
  cmp_res_t           cmp;
  logic [WAY_W-1:0]   pick_way;
  logic [MEM_AW-1:0]  wr_addr;
  store_wr_t          wr;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && (state_q == S_IDLE);
  // The result may be written once the previous one has gone or is leaving now.
  assign upd_fire   = (state_q == S_UPDATE) && (!out_valid_q || !out_stall_i);
  assign rd_en      = (state_q == S_READ);
  assign rd_addr    = base_q + MEM_AW'(way_q);

  always_comb begin
    if (hit_q) begin
      pick_way = hit_way_q;
    end else if (empty_found_q) begin
      pick_way = empty_way_q;
    end else begin
      pick_way = best_way_q;
    end
    wr_addr      = base_q + MEM_AW'(pick_way);
    wr.tag_we    = upd_fire && !hit_q;
    wr.valid_set = upd_fire && !hit_q;
    // In LRU mode a hit refreshes the stamp; an insertion always stamps.
    wr.stamp_we  = upd_fire && (!hit_q || !fifo_mode_q);
  end

  satlu_store #(
    .DEPTH (DEPTH),
    .AW    (MEM_AW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wr_i       (wr),
    .wr_tag_i   (tag_q),
    .wr_stamp_i (count_q),
    .rd_valid_o (rd_valid),
    .rd_tag_o   (rd_tag),
    .rd_stamp_o (rd_stamp)
  );

  satlu_way_cmp u_cmp (
    .ent_valid_i  (rd_valid),
    .ent_tag_i    (rd_tag),
    .ent_stamp_i  (rd_stamp),
    .look_tag_i   (tag_q),
    .best_stamp_i (best_stamp_q),
    .first_i      (way_q == '0),
    .res_o        (cmp)
  );

  // Sequencer: one way per read/compare pair, then a single write-back step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      way_q         <= '0;
      hit_q         <= 1'b0;
      empty_found_q <= 1'b0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // A result leaving in the same cycle as an update is simply replaced by the new one.
      if (out_valid_q && !out_stall_i && !upd_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            tag_q         <= look_tag;
            base_q        <= look_base;
            last_q        <= look_last;
            way_q         <= '0;
            hit_q         <= 1'b0;
            empty_found_q <= 1'b0;
            state_q       <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (cmp.match) begin
            hit_q     <= 1'b1;
            hit_way_q <= way_q;
            state_q   <= S_UPDATE;
          end else begin
            if (cmp.empty && !empty_found_q) begin
              empty_found_q <= 1'b1;
              empty_way_q   <= way_q;
            end
            if (cmp.older) begin
              best_way_q   <= way_q;
              best_stamp_q <= rd_stamp;
              best_tag_q   <= rd_tag;
            end
            if (way_q == last_q) begin
              state_q <= S_UPDATE;
            end else begin
              way_q   <= WAY_W'(way_q + 1'b1);
              state_q <= S_READ;
            end
          end
        end
        S_UPDATE: begin
          if (upd_fire) begin
            out_valid_q   <= 1'b1;
            out_hit_q     <= hit_q;
            out_way_q     <= WAY_OUT_W'(pick_way);
            out_filled_q  <= !hit_q && empty_found_q;
            out_evicted_q <= !hit_q && !empty_found_q;
            out_evtag_q   <= (!hit_q && !empty_found_q) ? best_tag_q : '0;
            count_q       <= count_q + 1'b1;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign way_o          = out_way_q;
  assign filled_empty_o = out_filled_q;
  assign evicted_o      = out_evicted_q;
  assign evicted_tag_o  = out_evtag_q;

`ifndef SYNTHESIS
  // Every result is exactly one of hit, fill of an empty way or eviction.
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({hit_o, filled_empty_o, evicted_o}))
    else $error("result is not exactly one of hit, fill and eviction");

  // The evicted tag reads as zero unless a line was really evicted.
  a_evtag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !evicted_o) |-> (evicted_tag_o == '0))
    else $error("evicted tag not zero without an eviction");

  // Once a transaction is taken the block refuses the next one until it is done.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted again straight after an acceptance");

  // The access counter advances exactly once per completed transaction.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |=> (count_q == $past(count_q) + 1'b1) && out_valid_q)
    else $error("access counter or result register not updated on completion");
`endif

endmodule
